// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/slrc_pkg.sv =====
// types, constants and table functions of the six-letter rotor cipher
// no dependencies; used by the top level and its checker
package slrc_pkg;

  localparam int LETTERS      = 6;
  localparam int ROTORS       = 3;
  localparam int COUNT_PERIOD = 18;
  localparam int LETTER_W     = 3;
  localparam int WIRE_W       = LETTERS * LETTER_W;
  localparam int COUNT_W      = 5;
  localparam int ROTOR_SEL_W  = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int TDATA_W      = 8;

  typedef logic [LETTER_W-1:0]          letter_t;
  typedef letter_t [LETTERS-1:0]         table_t;
  typedef logic [WIRE_W-1:0]             wiring_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [ROTOR_SEL_W-1:0]        rotor_sel_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
  typedef logic [TDATA_W-1:0]            tdata_t;

  // request kinds carried in tuser
  localparam logic CMD_RESTART  = 1'b0;
  localparam logic CMD_ENCIPHER = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t REG_ROTOR_ONE   = 2'd0;
  localparam cfg_idx_t REG_ROTOR_TWO   = 2'd1;
  localparam cfg_idx_t REG_ROTOR_THREE = 2'd2;
  localparam cfg_idx_t REG_REFLECTOR   = 2'd3;

  // register reset values: identity wiring, reflector a-b c-d e-f
  localparam wiring_t ROTOR_RST     = 18'd219345;
  localparam wiring_t REFLECTOR_RST = 18'd190218;

  localparam letter_t LAST_LETTER = letter_t'(LETTERS - 1);

  // decode one wiring entry; codes 0 and 7 map the letter to itself
  function automatic letter_t entry_of(wiring_t word, letter_t k);
    letter_t v;
    v = word[LETTER_W*k +: LETTER_W];
    if (v >= letter_t'(1) && v <= letter_t'(LETTERS)) begin
      return v - letter_t'(1);
    end
    return k;
  endfunction

  // next letter with wrap from f to a
  function automatic letter_t bump(letter_t v);
    return (v >= LAST_LETTER) ? letter_t'(0) : v + letter_t'(1);
  endfunction

  function automatic table_t identity_table();
    table_t t;
    for (int k = 0; k < LETTERS; k++) begin
      t[k] = letter_t'(k);
    end
    return t;
  endfunction

  // one rotor step: shift entries up one place and bump each value
  function automatic table_t rotate_table(table_t t);
    table_t n;
    n[0] = bump(t[LETTERS-1]);
    for (int i = 1; i < LETTERS; i++) begin
      n[i] = bump(t[i-1]);
    end
    return n;
  endfunction

  function automatic table_t build_forward(wiring_t w);
    table_t f;
    for (int k = 0; k < LETTERS; k++) begin
      f[k] = entry_of(w, letter_t'(k));
    end
    return f;
  endfunction

  // inverse from identity; a later entry wins where the wiring repeats a value
  function automatic table_t build_inverse(table_t f);
    table_t inv;
    inv = identity_table();
    for (int k = 0; k < LETTERS; k++) begin
      inv[f[k]] = letter_t'(k);
    end
    return inv;
  endfunction

endpackage

// ===== rtl/six_letter_rotor_cipher.sv =====
// six-letter rotor cipher: input register, table lookup chain, result register
// depends on slrc_pkg
//
// Enigma-style cipher over letters a..f (codes 0..5). A request with tuser 0
// restarts: the three rotor wirings are copied into working tables, inverse
// tables are built and the letter count clears; it gives no result. A request
// with tuser 1 enciphers tdata[2:0] (6 and 7 act as f) through rotors 1-3, the
// reflector and inverse rotors 3-1, returns one letter, then steps one rotor.
// One request is taken every cycle while results are taken. An accepted request
// waits in the input register, which feeds the combinational lookup chain and
// table update into the result register. A blocked result holds back an
// encipher request in the input register and the input stalls; a restart passes
// even then. Configuration writes take effect at once and belong only to idle
// periods; the reflector is read live, rotor wirings only at restart. After reset
// all tables are identity.
module six_letter_rotor_cipher (
  input  logic               clk,
  input  logic               rst_n,
  // input request channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  slrc_pkg::tdata_t   in_tdata,   // [2:0] letter_in, rest zero
  input  logic               in_tuser,   // [0] command
  // result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output slrc_pkg::tdata_t   out_tdata,  // [2:0] letter_out, rest zero
  // configuration write port
  input  logic               cfg_wr_en,
  input  slrc_pkg::cfg_idx_t cfg_index,
  input  slrc_pkg::wiring_t  cfg_wdata
);
  import slrc_pkg::*;

  // configuration registers
  wiring_t    wiring_r [ROTORS];
  wiring_t    refl_r;

  // input register
  logic       s1_valid_r;
  logic       s1_cmd_r;
  letter_t    s1_letter_r;

  // working state
  table_t     fwd_r [ROTORS];
  table_t     inv_r [ROTORS];
  table_t     fwd_nxt [ROTORS];
  table_t     inv_nxt [ROTORS];
  count_t     count_r;
  count_t     count_nxt;
  count_t     count_inc;
  rotor_sel_t step_sel;

  // result register
  logic       out_valid_r;
  letter_t    out_letter_r;

  logic       advance;
  logic       in_acc;
  letter_t    x_in;
  letter_t    x1, x2, x3, x4, x5, x6, x7;

  // the input register moves on unless an encipher result is blocked
  assign advance   = s1_valid_r &&
                     (s1_cmd_r == CMD_RESTART || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROTORS; r++) begin
        wiring_r[r] <= ROTOR_RST;
      end
      refl_r <= REFLECTOR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROTOR_ONE:   wiring_r[0] <= cfg_wdata;
        REG_ROTOR_TWO:   wiring_r[1] <= cfg_wdata;
        REG_ROTOR_THREE: wiring_r[2] <= cfg_wdata;
        REG_REFLECTOR:   refl_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= in_tuser;
      s1_letter_r <= in_tdata[LETTER_W-1:0];
    end
  end

  // lookup chain: rotors, reflector, inverse rotors
  always_comb begin
    x_in = (s1_letter_r > LAST_LETTER) ? LAST_LETTER : s1_letter_r;
    x1   = fwd_r[0][x_in];
    x2   = fwd_r[1][x1];
    x3   = fwd_r[2][x2];
    x4   = entry_of(refl_r, x3);
    x5   = inv_r[2][x4];
    x6   = inv_r[1][x5];
    x7   = inv_r[0][x6];
  end

  // count advance and choice of rotor to step
  always_comb begin
    count_inc = (count_r == count_t'(COUNT_PERIOD - 1)) ? count_t'(0)
                                                        : count_r + count_t'(1);
    if (count_inc < count_t'(LETTERS)) begin
      step_sel = rotor_sel_t'(0);
    end else if (count_inc < count_t'(2 * LETTERS)) begin
      step_sel = rotor_sel_t'(1);
    end else begin
      step_sel = rotor_sel_t'(2);
    end
  end

  // table update: reload on restart, one rotor step after each letter
  always_comb begin
    for (int r = 0; r < ROTORS; r++) begin
      fwd_nxt[r] = fwd_r[r];
      inv_nxt[r] = inv_r[r];
    end
    count_nxt = count_r;
    if (advance) begin
      if (s1_cmd_r == CMD_RESTART) begin
        for (int r = 0; r < ROTORS; r++) begin
          fwd_nxt[r] = build_forward(wiring_r[r]);
          inv_nxt[r] = build_inverse(fwd_nxt[r]);
        end
        count_nxt = count_t'(0);
      end else begin
        fwd_nxt[step_sel] = rotate_table(fwd_r[step_sel]);
        inv_nxt[step_sel] = rotate_table(inv_r[step_sel]);
        count_nxt         = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROTORS; r++) begin
        fwd_r[r] <= identity_table();
        inv_r[r] <= identity_table();
      end
      count_r <= count_t'(0);
    end else begin
      for (int r = 0; r < ROTORS; r++) begin
        fwd_r[r] <= fwd_nxt[r];
        inv_r[r] <= inv_nxt[r];
      end
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_cmd_r == CMD_ENCIPHER) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_cmd_r == CMD_ENCIPHER) begin
      out_letter_r <= x7;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tdata_t'(out_letter_r);

endmodule

// ===== rtl/slrc_checker.sv =====
// port-level checks for the six-letter rotor cipher, bound to the top level
// depends on slrc_pkg and assert_macros.svh
`include "assert_macros.svh"

module slrc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input slrc_pkg::tdata_t   out_tdata   // [2:0] letter_out, rest zero
);
  import slrc_pkg::*;

  logic in_acc;
  logic out_free;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid || out_tready;

  // input side never stalls while the result side can drain
  `ASSERT_IMP(a_ready_when_free, clk, rst_n, out_free, in_tready)

  // a result is always a letter a..f with zero padding
  `ASSERT_IMP(a_letter_range, clk, rst_n, out_tvalid,
    out_tdata[LETTER_W-1:0] <= LAST_LETTER && out_tdata[TDATA_W-1:LETTER_W] == '0)

  // with no request accepted, the output first empty and then drained, no result appears
  `ASSERT_NXT(a_no_invented_result, clk, rst_n,
    (!out_tvalid && !in_acc) ##1 (!in_acc && out_free), !out_tvalid)

  // a stalled result holds
  `ASSERT_NXT(a_result_holds, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata))

endmodule

bind six_letter_rotor_cipher slrc_checker u_slrc_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for six_letter_rotor_cipher: directed and random requests,
// a shadow cipher predicts every result letter; depends on slrc_pkg and the rtl
`timescale 1ns / 100ps

module testbench;
  import slrc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 133;

  // shadow copy of the cipher state plus the queue of letters still owed
  class cipher_checker;
    wiring_t     rotor_wiring[ROTORS];
    wiring_t     reflector_wiring;
    letter_t     fwd_map[ROTORS][LETTERS];
    letter_t     inv_map[ROTORS][LETTERS];
    int unsigned letter_count;
    letter_t     pending_letters[$];
    int unsigned errors;

    function new();
      foreach (rotor_wiring[r]) rotor_wiring[r] = ROTOR_RST;
      reflector_wiring = REFLECTOR_RST;
      for (int r = 0; r < ROTORS; r++) begin
        for (int k = 0; k < LETTERS; k++) begin
          fwd_map[r][k] = letter_t'(k);
          inv_map[r][k] = letter_t'(k);
        end
      end
      letter_count = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, wiring_t value);
      case (idx)
        REG_ROTOR_ONE:   rotor_wiring[0] = value;
        REG_ROTOR_TWO:   rotor_wiring[1] = value;
        REG_ROTOR_THREE: rotor_wiring[2] = value;
        REG_REFLECTOR:   reflector_wiring = value;
        default: ;
      endcase
    endfunction

    // codes 1..6 name letters a..f, anything else leaves the letter alone
    function letter_t wiring_entry(wiring_t w, int k);
      letter_t v;
      v = w[LETTER_W*k +: LETTER_W];
      if (v >= 1 && v <= LETTERS) return letter_t'(v - 1);
      return letter_t'(k);
    endfunction

    function letter_t next_letter(letter_t v);
      return (v >= LAST_LETTER) ? letter_t'(0) : letter_t'(v + 1);
    endfunction

    // restart: forward maps from the wirings, inverse built over identity
    function void load_rotors();
      for (int r = 0; r < ROTORS; r++) begin
        for (int k = 0; k < LETTERS; k++) begin
          inv_map[r][k] = letter_t'(k);
        end
        for (int k = 0; k < LETTERS; k++) begin
          fwd_map[r][k] = wiring_entry(rotor_wiring[r], k);
          inv_map[r][fwd_map[r][k]] = letter_t'(k);
        end
      end
      letter_count = 0;
    endfunction

    function void step_rotor(int r);
      letter_t f_last, i_last;
      f_last = fwd_map[r][LETTERS-1];
      i_last = inv_map[r][LETTERS-1];
      for (int i = LETTERS - 1; i >= 1; i--) begin
        fwd_map[r][i] = next_letter(fwd_map[r][i-1]);
        inv_map[r][i] = next_letter(inv_map[r][i-1]);
      end
      fwd_map[r][0] = next_letter(f_last);
      inv_map[r][0] = next_letter(i_last);
    endfunction

    // one accepted request
    function void take_request(logic cmd, letter_t letter);
      letter_t x;
      int r;
      if (cmd == CMD_RESTART) begin
        load_rotors();
        return;
      end
      x = (letter > LAST_LETTER) ? LAST_LETTER : letter;
      for (r = 0; r < ROTORS; r++) x = fwd_map[r][x];
      x = wiring_entry(reflector_wiring, x);
      for (r = ROTORS - 1; r >= 0; r--) x = inv_map[r][x];
      pending_letters.push_back(x);
      letter_count = (letter_count + 1) % COUNT_PERIOD;
      step_rotor((letter_count / LETTERS) % ROTORS);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_letter(tdata_t data);
      letter_t want;
      if (pending_letters.size() == 0) begin
        report($sformatf("result %0d with nothing pending", data));
        return;
      end
      want = pending_letters.pop_front();
      if (data[LETTER_W-1:0] !== want)
        report($sformatf("letter_out %0d, predicted %0d", data[LETTER_W-1:0], want));
      if (data[TDATA_W-1:LETTER_W] !== '0)
        report($sformatf("padding bits of result not zero: %0h", data));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  tdata_t             in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  tdata_t             out_tdata;
  logic               cfg_wr_en;
  cfg_idx_t           cfg_index;
  wiring_t            cfg_wdata;

  cipher_checker shadow = new();
  bit    sender_gaps  = 1'b1;
  bit    recv_gaps    = 1'b1;
  bit    hold_request = 1'b0;
  int    idle_cycles  = 0;

  six_letter_rotor_cipher DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offer one request, with optional random gaps in front of it
  task automatic send(logic cmd, letter_t letter);
    while (sender_gaps && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= tdata_t'(letter);
    do @(posedge clk); while (!in_tready);
    shadow.take_request(cmd, letter);
  endtask

  // stop offering, let owed results and any restart in flight clear
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (shadow.pending_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, wiring_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    shadow.write_reg(idx, value);
  endtask

  function automatic wiring_t shuffled_wiring(bit as_pairs);
    letter_t p[LETTERS];
    letter_t t;
    int      j;
    wiring_t w;
    for (int k = 0; k < LETTERS; k++) p[k] = letter_t'(k);
    for (int k = LETTERS - 1; k >= 1; k--) begin
      j = $urandom_range(k);
      t = p[k];
      p[k] = p[j];
      p[j] = t;
    end
    w = '0;
    if (as_pairs) begin
      // three swapped pairs taken from the shuffle
      for (int i = 0; i < LETTERS; i += 2) begin
        w[LETTER_W*int'(p[i]) +: LETTER_W]   = letter_t'(p[i+1] + 1);
        w[LETTER_W*int'(p[i+1]) +: LETTER_W] = letter_t'(p[i] + 1);
      end
    end else begin
      for (int k = 0; k < LETTERS; k++) w[LETTER_W*k +: LETTER_W] = letter_t'(p[k] + 1);
    end
    return w;
  endfunction

  function automatic wiring_t pick_wiring(bit reflector);
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return shuffled_wiring(reflector);
    if (roll < 72) return wiring_t'($urandom_range(262143));
    if (roll < 80) return '0;
    if (roll < 88) return '1;
    return reflector ? REFLECTOR_RST : ROTOR_RST;
  endfunction

  task automatic program_registers();
    write_reg(REG_ROTOR_ONE,   pick_wiring(1'b0));
    write_reg(REG_ROTOR_TWO,   pick_wiring(1'b0));
    write_reg(REG_ROTOR_THREE, pick_wiring(1'b0));
    write_reg(REG_REFLECTOR,   pick_wiring(1'b1));
    cfg_wr_en <= 1'b0;
  endtask

  // mostly runs of encipher requests, with stray restarts and bad letters
  task automatic run_phase(int n_items, bit lead_restart);
    int roll;
    if (lead_restart) send(CMD_RESTART, letter_t'($urandom_range(7)));
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 4)
        send(CMD_RESTART, letter_t'($urandom_range(7)));
      else if (roll < 12)
        send(CMD_ENCIPHER, letter_t'($urandom_range(7)));
      else
        send(CMD_ENCIPHER, letter_t'($urandom_range(LETTERS - 1)));
    end
  endtask

  // receiver: random backpressure, or one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_tready <= !(recv_gaps && $urandom_range(99) < 11);
      end
    end
  end

  // result check on each accepted result
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) shadow.check_letter(out_tdata);
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_RESTART;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_ROTOR_ONE;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity tables after reset, every letter code including 6 and 7
    for (int v = 0; v < 8; v++) send(CMD_ENCIPHER, letter_t'(v));
    send(CMD_RESTART, letter_t'(0));
    for (int v = 0; v < 4; v++) send(CMD_ENCIPHER, letter_t'(v));

    // bad codes 0 and 7, a repeated rotor value, a reflector with bad entries
    wait_idle();
    write_reg(REG_ROTOR_ONE,   '0);
    write_reg(REG_ROTOR_TWO,   '1);
    write_reg(REG_ROTOR_THREE, {6{3'd6}});
    write_reg(REG_REFLECTOR,   {3'd5, 3'd6, 3'd7, 3'd1, 3'd0, 3'd3});
    cfg_wr_en <= 1'b0;
    send(CMD_RESTART, letter_t'(7));
    for (int v = 0; v < 8; v++) send(CMD_ENCIPHER, letter_t'(v));

    // random phases; some skip the restart so old tables meet new registers
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      sender_gaps = !(p == 2 || p == 3);
      recv_gaps   = !(p == 2 || p == 3);
      program_registers();
      if (p == 5) hold_request = 1'b1;
      run_phase(PHASE_ITEMS, (p % 4) != 3);
    end

    wait_idle();
    if (shadow.errors == 0 && shadow.pending_letters.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
